[rtl/core/newton_square_root_core_macros.svh]
// Assertion macros shared by the square root checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef NEWTON_SQUARE_ROOT_CORE_MACROS_SVH
`define NEWTON_SQUARE_ROOT_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define NSQRT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsqrt: same-cycle check failed");

// next-cycle implication, disabled in reset
`define NSQRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsqrt: next-cycle check failed");

`endif

[rtl/core/nsqrt_pkg.sv]
// Shared constants and controller/datapath interface types for the square root core.
// No dependencies.
package nsqrt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_STEPS_DEF  = 64;

  localparam int OPERAND_W = 32;
  localparam int ROOT_W    = 32;
  localparam int TOL_W     = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture operand, select first guess, clear step count
    logic div_start;    // set up a division by the current guess
    logic div_step;     // one restoring quotient bit
    logic average;      // new guess = (guess + quotient) / 2
    logic finish_zero;  // zero operand result
    logic finish_ok;    // converged result
    logic finish_cap;   // step limit result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic operand_zero;
    logic div_last;
    logic converged;
    logic at_cap;
  } status_t;

endpackage

[rtl/core/nsqrt_ctrl.sv]
// Sequencer for the square root core: issues datapath commands per Newton step.
// Depends on nsqrt_pkg (cmd_t, status_t).
module nsqrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  nsqrt_pkg::status_t status,
  output nsqrt_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    AVERAGE,
    CHECK
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: begin
        cmd.load        = start;
        cmd.div_start   = start && !status.operand_zero;
        cmd.finish_zero = start && status.operand_zero;
      end
      DIVIDE:  cmd.div_step = 1'b1;
      AVERAGE: cmd.average  = 1'b1;
      CHECK: begin
        cmd.finish_ok  = status.converged;
        cmd.finish_cap = !status.converged && status.at_cap;
        cmd.div_start  = !status.converged && !status.at_cap;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            if (status.operand_zero) begin
              done <= 1'b1;
            end else begin
              state <= DIVIDE;
              busy  <= 1'b1;
            end
          end
        end
        DIVIDE: begin
          if (status.div_last) state <= AVERAGE;
        end
        AVERAGE: state <= CHECK;
        CHECK: begin
          if (status.converged || status.at_cap) begin
            state <= IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            state <= DIVIDE;
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

[rtl/core/nsqrt_datapath.sv]
// Datapath for the square root core: operand and guess registers, bit-serial
// restoring divider, averaging, convergence test and tolerance register.
// Depends on nsqrt_pkg.
module nsqrt_datapath #(
  parameter int DATA_WIDTH = nsqrt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nsqrt_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS  = nsqrt_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nsqrt_pkg::cmd_t                     cmd,
  output nsqrt_pkg::status_t                  status,
  input  logic [nsqrt_pkg::OPERAND_W-1:0]     operand,
  input  logic                                tol_we,
  input  logic [nsqrt_pkg::TOL_W-1:0]         tol_data,
  output logic [nsqrt_pkg::ROOT_W-1:0]        root,
  output logic                                hit_limit
);

  localparam int W   = DATA_WIDTH;
  localparam int DVW = DATA_WIDTH + FRAC_BITS;
  localparam int DCW = $clog2(DVW);
  localparam int SCW = $clog2(MAX_STEPS + 1);
  localparam int CW  = (W > nsqrt_pkg::TOL_W) ? W : nsqrt_pkg::TOL_W;

  logic [W-1:0]                 x_reg;
  logic [W-1:0]                 guess;
  logic [W-1:0]                 next_g;
  logic [DVW-1:0]               dividend;
  logic [W-1:0]                 rem;
  logic [W-1:0]                 quo;
  logic                         sat;
  logic [DCW-1:0]               bit_cnt;
  logic [SCW-1:0]               steps;
  logic [nsqrt_pkg::TOL_W-1:0]  tol;

  logic [W-1:0] x_in;
  logic [W-1:0] x_half;
  logic [W-1:0] guess_next;
  logic [W:0]   rem_sh;
  logic         ge;
  logic [W-1:0] quo_eff;
  logic [W:0]   sum;
  logic [W-1:0] diff;

  assign x_in   = cmd.load ? W'(operand) : x_reg;
  assign x_half = x_in >> 1;

  // guess for the next division: first guess on load, refined guess otherwise
  always_comb begin
    if (cmd.load) guess_next = (x_half == '0) ? W'(1) : x_half;
    else          guess_next = (next_g == '0) ? W'(1) : next_g;
  end

  assign rem_sh  = {rem, dividend[DVW-1]};
  assign ge      = rem_sh >= {1'b0, guess};
  assign quo_eff = sat ? '1 : quo;
  assign sum     = {1'b0, guess} + {1'b0, quo_eff};
  assign diff    = (guess > next_g) ? (guess - next_g) : (next_g - guess);

  assign status.operand_zero = (W'(operand) == '0);
  assign status.div_last     = (bit_cnt == '0);
  assign status.converged    = CW'(diff) < CW'(tol);
  assign status.at_cap       = (steps == SCW'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= nsqrt_pkg::TOL_RESET;
    end else if (tol_we) begin
      tol <= tol_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg <= x_in;
      steps <= '0;
    end
    if (cmd.div_start) begin
      guess    <= guess_next;
      dividend <= DVW'(x_in) << FRAC_BITS;
      rem      <= '0;
      quo      <= '0;
      sat      <= 1'b0;
      bit_cnt  <= DCW'(DVW - 1);
    end
    if (cmd.div_step) begin
      rem      <= ge ? W'(rem_sh - {1'b0, guess}) : rem_sh[W-1:0];
      dividend <= dividend << 1;
      sat      <= sat | quo[W-1];   // a quotient bit shifted out: saturate
      quo      <= {quo[W-2:0], ge};
      bit_cnt  <= bit_cnt - 1'b1;
    end
    if (cmd.average) begin
      next_g <= sum[W:1];
      steps  <= steps + 1'b1;
    end
    if (cmd.finish_zero) begin
      root      <= '0;
      hit_limit <= 1'b0;
    end
    if (cmd.finish_ok || cmd.finish_cap) begin
      root      <= nsqrt_pkg::ROOT_W'(next_g);
      hit_limit <= cmd.finish_cap;
    end
  end

endmodule

[rtl/core/newton_square_root_core.sv]
// Top level of the Newton-Raphson square root core (unsigned fixed point).
// Depends on nsqrt_pkg, nsqrt_ctrl and nsqrt_datapath.
//
// A request is taken when start is high and busy is low. Each request gives
// one result: root and hit_limit are valid from the cycle in which done is
// high; done is a one-cycle strobe. The receiver cannot stall them, so
// capture them then. A zero operand answers in the cycle after the request.
// Otherwise each Newton step is a division by the current guess in the
// bit-serial restoring divider, which forms one quotient bit per cycle,
// followed by an averaging state and a test state. A search takes at most
// MAX_STEPS Newton steps; hit_limit flags a search that ran the full
// MAX_STEPS without meeting the tolerance. tolerance may be written only
// while busy is low; cfg_ready is low while a request is in progress.
module newton_square_root_core #(
  parameter int DATA_WIDTH = nsqrt_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nsqrt_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS  = nsqrt_pkg::MAX_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [nsqrt_pkg::OPERAND_W-1:0]  operand,
  output logic                             done,
  output logic [nsqrt_pkg::ROOT_W-1:0]     root,
  output logic                             hit_limit,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nsqrt_pkg::TOL_W-1:0]      tolerance
);

  nsqrt_pkg::cmd_t    cmd;
  nsqrt_pkg::status_t status;

  assign cfg_ready = !busy;

  nsqrt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  nsqrt_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .operand   (operand),
    .tol_we    (cfg_valid && cfg_ready),
    .tol_data  (tolerance),
    .root      (root),
    .hit_limit (hit_limit)
  );

endmodule

[rtl/core/nsqrt_checker.sv]
// Port-level checks for newton_square_root_core, bound to the top level.
// Depends on nsqrt_pkg and newton_square_root_core_macros.svh.
`include "newton_square_root_core_macros.svh"

module nsqrt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [nsqrt_pkg::OPERAND_W-1:0]  operand,
  input logic                             done,
  input logic [nsqrt_pkg::ROOT_W-1:0]     root,
  input logic                             hit_limit,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [nsqrt_pkg::TOL_W-1:0]      tolerance
);

  // a result never appears while a request is still in progress
  `NSQRT_ASSERT_NOW(a_done_not_busy, clk, rst, done, !busy)

  // every finished request reports a result
  `NSQRT_ASSERT_NOW(a_finish_gives_done, clk, rst, $fell(busy), done)

  // zero operand: immediate zero root, no limit flag
  `NSQRT_ASSERT_NEXT(a_zero_fast, clk, rst, start && !busy && operand == '0,
                     done && root == '0 && !hit_limit)

  // nonzero operand starts an iteration
  `NSQRT_ASSERT_NEXT(a_nonzero_busy, clk, rst, start && !busy && operand != '0,
                     busy && !done)

  // tolerance is closed while iterating
  `NSQRT_ASSERT_NOW(a_cfg_closed, clk, rst, busy, !cfg_ready)

endmodule

bind newton_square_root_core nsqrt_checker u_nsqrt_checker (.*);
